// ===== rtl/longest_palindromic_substring_assert.svh =====
// Assertion macros for the palindrome search checker.
`ifndef LONGEST_PALINDROMIC_SUBSTRING_ASSERT_SVH
`define LONGEST_PALINDROMIC_SUBSTRING_ASSERT_SVH

// Clocked check, masked while reset is asserted.
`define LPS_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("lps check failed");

// Clocked check that also runs across reset.
`define LPS_ASSERT_RST(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("lps reset check failed");

`endif

// ===== rtl/lps_pkg.sv =====
// Shared constants and types for the palindrome search block.
package lps_pkg;

  localparam int MAX_LEN_DEF = 256;
  localparam int BYTE_W      = 8;
  localparam int START_W     = 8;
  localparam int LENGTH_W    = 9;
  localparam int CHUNK_MAX   = 32;

  typedef enum logic [2:0] {
    ST_LOAD = 3'b001,
    ST_CALC = 3'b010,
    ST_SCAN = 3'b100
  } state_t;

  typedef struct packed {
    logic start;
    logic step;
    logic clr;
  } cell_ctl_t;

  typedef struct packed {
    logic init;
    logic calc;
    logic scan;
  } trk_ctl_t;

endpackage

// ===== rtl/longest_palindromic_substring.sv =====
// The result follows the last byte's transfer in three phases: one diagonal per cycle down
// the cell chain, a settling step in which the tracker commits the best diagonal, then a scan
// in chunks of up to 32 cells that skips the chunks before the first match.
// Throughput: one byte per cycle while loading; no byte is taken until the result is stored.
// Reset (rst_n low, synchronous) empties the string, clears the overflow flag and drops
// any pending result; the character cells need no clearing.
module longest_palindromic_substring #(
  parameter int MAX_LEN = lps_pkg::MAX_LEN_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [lps_pkg::BYTE_W-1:0]   in_data_byte,
  input  logic                         in_last_byte,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [lps_pkg::START_W-1:0]  out_best_start,
  output logic [lps_pkg::LENGTH_W-1:0] out_best_length,
  output logic                         out_truncated
);
  import lps_pkg::*;

  localparam int CNT_W = $clog2(MAX_LEN + 1);
  localparam int IDX_W = $clog2(MAX_LEN);

  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic               ovf_r, ovf_nxt;
  logic [CNT_W-1:0]   len_r, len_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [START_W-1:0] out_start_r;
  logic [LENGTH_W-1:0] out_length_r;
  logic               out_trunc_r;

  logic               acc;
  logic               room;
  logic               finish;
  logic               out_free;
  logic [CNT_W-1:0]   calc_len;
  cell_ctl_t          cctl;
  trk_ctl_t           tctl;
  logic               found;
  logic [IDX_W-1:0]   trk_start;
  logic [CNT_W-1:0]   trk_len;

  logic [MAX_LEN-1:0] wr_sel;
  logic [MAX_LEN-1:0] hit_w;
  logic [MAX_LEN-1:0] act_w;
  logic [MAX_LEN-1:0] p2_w;
  logic [BYTE_W-1:0]  partner_w [MAX_LEN];

  assign in_ready = (state_r == ST_LOAD);
  assign acc      = in_valid && in_ready;
  assign room     = (count_r < CNT_W'(MAX_LEN));
  assign calc_len = len_r + CNT_W'(1);
  assign out_free = !out_valid_r || out_ready;

  for (genvar i = 0; i < MAX_LEN; i++) begin : g_cell
    logic [BYTE_W-1:0] nb_partner;
    logic              nb_act;
    logic              nb_p2;

    if (i == MAX_LEN - 1) begin : g_end
      assign nb_partner = '0;
      assign nb_act     = 1'b0;
      assign nb_p2      = 1'b1;
    end else begin : g_mid
      assign nb_partner = partner_w[i+1];
      assign nb_act     = act_w[i+1];
      assign nb_p2      = p2_w[i+1];
    end

    assign wr_sel[i] = acc && room && (count_r == CNT_W'(i));

    lps_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctl        (cctl),
      .wr_en      (wr_sel[i]),
      .din        (in_data_byte),
      .nb_partner (nb_partner),
      .nb_act     (nb_act),
      .nb_p2      (nb_p2),
      .partner    (partner_w[i]),
      .act        (act_w[i]),
      .p2         (p2_w[i]),
      .hit        (hit_w[i])
    );
  end

  lps_track #(
    .MAX_LEN (MAX_LEN)
  ) u_track (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctl         (tctl),
    .hit         (hit_w),
    .calc_len    (calc_len),
    .found       (found),
    .best_start  (trk_start),
    .best_length (trk_len)
  );

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    ovf_nxt       = ovf_r;
    len_nxt       = len_r;
    out_valid_nxt = out_valid_r;
    cctl          = '0;
    tctl          = '0;
    finish        = 1'b0;
    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;
    unique case (state_r)
      ST_LOAD: begin
        if (acc) begin
          if (room) count_nxt = count_r + CNT_W'(1);
          else      ovf_nxt   = 1'b1;
          if (in_last_byte) begin
            state_nxt  = ST_CALC;
            len_nxt    = CNT_W'(1);
            cctl.start = 1'b1;
            tctl.init  = 1'b1;
          end
        end
      end
      ST_CALC: begin
        // The cycle after the last diagonal lets the tracker commit it.
        if (len_r == count_r) begin
          state_nxt = ST_SCAN;
        end else begin
          cctl.step = 1'b1;
          tctl.calc = 1'b1;
          len_nxt   = calc_len;
        end
      end
      ST_SCAN: begin
        if (!found) begin
          tctl.scan = 1'b1;
        end else if (out_free) begin
          finish        = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_LOAD;
          count_nxt     = '0;
          ovf_nxt       = 1'b0;
          cctl.clr      = 1'b1;
        end
      end
      default: state_nxt = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      count_r     <= '0;
      ovf_r       <= 1'b0;
      len_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      ovf_r       <= ovf_nxt;
      len_r       <= len_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      out_start_r  <= START_W'(trk_start);
      out_length_r <= LENGTH_W'(trk_len);
      out_trunc_r  <= ovf_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_best_start  = out_start_r;
  assign out_best_length = out_length_r;
  assign out_truncated   = out_trunc_r;

endmodule

// ===== rtl/lps_cell.sv =====
// One cell of the diagonal chain: a stored character and its slice of the last two diagonals.
module lps_cell (
  input  logic                      clk,
  input  logic                      rst_n,
  input  lps_pkg::cell_ctl_t        ctl,
  input  logic                      wr_en,
  input  logic [lps_pkg::BYTE_W-1:0] din,
  input  logic [lps_pkg::BYTE_W-1:0] nb_partner,
  input  logic                      nb_act,
  input  logic                      nb_p2,
  output logic [lps_pkg::BYTE_W-1:0] partner,
  output logic                      act,
  output logic                      p2,
  output logic                      hit
);
  import lps_pkg::*;

  logic [BYTE_W-1:0] char_r;
  logic [BYTE_W-1:0] partner_r;
  logic              act_r;
  logic              p1_r;
  logic              p2_r;

  // Neighbor holds the far end of the current span and the inner span's result.
  assign hit     = nb_act && (char_r == nb_partner) && nb_p2;
  assign partner = partner_r;
  assign act     = act_r;
  assign p2      = p2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r <= 1'b0;
    end else if (ctl.clr) begin
      act_r <= 1'b0;
    end else if (wr_en) begin
      act_r <= 1'b1;
    end else if (ctl.step) begin
      act_r <= nb_act;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      char_r    <= din;
      partner_r <= din;
    end else if (ctl.step) begin
      partner_r <= nb_partner;
    end
    // Spans of length zero and one always match.
    if (ctl.start) begin
      p1_r <= 1'b1;
      p2_r <= 1'b1;
    end else if (ctl.step) begin
      p1_r <= hit;
      p2_r <= p1_r;
    end
  end

endmodule

// ===== rtl/lps_track.sv =====
// Best-match tracker: keeps the latest diagonal with a match and finds its first set cell.
module lps_track #(
  parameter int MAX_LEN = lps_pkg::MAX_LEN_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  lps_pkg::trk_ctl_t                  ctl,
  input  logic [MAX_LEN-1:0]                 hit,
  input  logic [$clog2(MAX_LEN+1)-1:0]       calc_len,
  output logic                               found,
  output logic [$clog2(MAX_LEN)-1:0]         best_start,
  output logic [$clog2(MAX_LEN+1)-1:0]       best_length
);
  import lps_pkg::*;

  localparam int CNT_W = $clog2(MAX_LEN + 1);
  localparam int IDX_W = $clog2(MAX_LEN);
  localparam int CH    = (MAX_LEN < CHUNK_MAX) ? MAX_LEN : CHUNK_MAX;
  localparam int CH_W  = $clog2(CH);
  localparam int NGRP  = (MAX_LEN + CH - 1) / CH;
  localparam int PAD   = NGRP * CH;

  function automatic logic [CH_W-1:0] low_idx(input logic [CH-1:0] v);
    logic [CH_W-1:0] idx;
    idx = '0;
    for (int k = CH - 1; k >= 0; k--) begin
      if (v[k]) idx = CH_W'(k);
    end
    return idx;
  endfunction

  logic [PAD-1:0]   hv_pad;
  logic [NGRP-1:0]  grp_nxt;
  logic [PAD-1:0]   hv_r;
  logic [NGRP-1:0]  grp_r;
  logic [CNT_W-1:0] hl_r;
  logic             pv_r;
  logic [PAD-1:0]   bvec_r;
  logic [CNT_W-1:0] blen_r;
  logic [IDX_W-1:0] bst_r;

  assign hv_pad = PAD'(hit);

  for (genvar g = 0; g < NGRP; g++) begin : g_grp
    assign grp_nxt[g] = |hv_pad[g*CH +: CH];
  end

  assign found       = |bvec_r[CH-1:0];
  assign best_start  = bst_r + IDX_W'(low_idx(bvec_r[CH-1:0]));
  assign best_length = blen_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r <= 1'b0;
    end else begin
      pv_r <= ctl.calc;
    end
  end

  always_ff @(posedge clk) begin
    hv_r  <= hv_pad;
    grp_r <= grp_nxt;
    hl_r  <= calc_len;
    if (ctl.init) begin
      bvec_r <= PAD'(1);
      blen_r <= CNT_W'(1);
      bst_r  <= '0;
    end else begin
      // A diagonal with any match is always longer than the best so far.
      if (pv_r && (|grp_r)) begin
        bvec_r <= hv_r;
        blen_r <= hl_r;
      end
      if (ctl.scan) begin
        bvec_r <= bvec_r >> CH;
        bst_r  <= bst_r + IDX_W'(CH);
      end
    end
  end

endmodule

// ===== rtl/lps_chk.sv =====
// Port-level checker for the palindrome search block, bound to the top level.
`include "longest_palindromic_substring_assert.svh"

module lps_chk (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         in_last_byte,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [lps_pkg::START_W-1:0]  out_best_start,
  input logic [lps_pkg::LENGTH_W-1:0] out_best_length,
  input logic                         out_truncated
);
  import lps_pkg::*;

  // A stalled result holds.
  `LPS_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid &&
              $stable(out_best_start) && $stable(out_best_length) && $stable(out_truncated))

  // Every palindrome found is at least one byte long.
  `LPS_ASSERT(a_len_nonzero, clk, rst_n, out_valid |-> out_best_length != '0)

  // Closing a string starts the search, so intake stops.
  `LPS_ASSERT(a_last_stops_intake, clk, rst_n, in_valid && in_ready && in_last_byte |=> !in_ready)

  // Reset leaves no result pending and the block ready for bytes.
  `LPS_ASSERT_RST(a_reset_idle, clk, !rst_n |=> !out_valid && in_ready)

endmodule

bind longest_palindromic_substring lps_chk u_lps_chk (.*);

// ===== verif/lps_scoreboard_pkg.sv =====
// Scoreboard class that predicts and checks palindrome search results.
`timescale 1ns / 100ps

package lps_scoreboard_pkg;
  import lps_pkg::*;

  typedef struct packed {
    logic [START_W-1:0]  start;
    logic [LENGTH_W-1:0] length;
    logic                truncated;
  } pal_result_t;

  class palindrome_scoreboard;
    logic [BYTE_W-1:0] char_buf [MAX_LEN_DEF];
    int                char_cnt;
    bit                overflow;
    pal_result_t       expected_q [$];
    int unsigned       fail_count;

    function new();
      char_cnt   = 0;
      overflow   = 1'b0;
      fail_count = 0;
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    // Longest palindrome over the stored bytes, earliest start on a tie.
    function pal_result_t longest_match();
      bit          diag_two [MAX_LEN_DEF+1];
      bit          diag_one [MAX_LEN_DEF+1];
      bit          diag_cur [MAX_LEN_DEF+1];
      pal_result_t res;
      int          best_len;
      int          best_at;
      bit          hit;
      for (int k = 0; k <= MAX_LEN_DEF; k++) begin
        diag_two[k] = 1'b1;
        diag_one[k] = 1'b1;
        diag_cur[k] = 1'b0;
      end
      best_len = 1;
      best_at  = 0;
      for (int len = 2; len <= char_cnt; len++) begin
        for (int i = 0; i + len <= char_cnt; i++) begin
          hit = (char_buf[i] == char_buf[i+len-1]) && diag_two[i+1];
          diag_cur[i] = hit;
          if (hit && len > best_len) begin
            best_len = len;
            best_at  = i;
          end
        end
        diag_two = diag_one;
        diag_one = diag_cur;
      end
      res.start     = best_at[START_W-1:0];
      res.length    = best_len[LENGTH_W-1:0];
      res.truncated = overflow;
      return res;
    endfunction

    function void note_byte(logic [BYTE_W-1:0] b, logic last);
      if (char_cnt < MAX_LEN_DEF) begin
        char_buf[char_cnt] = b;
        char_cnt++;
      end else begin
        overflow = 1'b1;
      end
      if (last) begin
        expected_q.push_back(longest_match());
        char_cnt = 0;
        overflow = 1'b0;
      end
    endfunction

    task report_mismatch(string msg);
      fail_count++;
      $display("MISMATCH @%0t: %s", $time, msg);
    endtask

    task check_result(logic [START_W-1:0] st, logic [LENGTH_W-1:0] ln, logic tr);
      pal_result_t want;
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result start=%0d length=%0d truncated=%0b",
                                  st, ln, tr));
        return;
      end
      want = expected_q.pop_front();
      if (st !== want.start)
        report_mismatch($sformatf("best_start got %0d want %0d", st, want.start));
      if (ln !== want.length)
        report_mismatch($sformatf("best_length got %0d want %0d", ln, want.length));
      if (tr !== want.truncated)
        report_mismatch($sformatf("truncated got %0b want %0b", tr, want.truncated));
    endtask
  endclass

endpackage

// ===== verif/tb_longest_palindromic_substring.sv =====
// Top-level testbench for the longest palindromic substring block.
`timescale 1ns / 100ps

module tb_longest_palindromic_substring;
  import lps_pkg::*;
  import lps_scoreboard_pkg::*;

  localparam int DUT_MAX_LEN    = MAX_LEN_DEF;
  localparam int ITEM_TARGET    = 1750;
  localparam int HOLD_CYCLES    = 400;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int TAIL_CYCLES    = 300;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  logic [BYTE_W-1:0]   in_data_byte;
  logic                in_last_byte;
  logic                out_valid;
  logic                out_ready;
  logic [START_W-1:0]  out_best_start;
  logic [LENGTH_W-1:0] out_best_length;
  logic                out_truncated;

  palindrome_scoreboard sb;
  logic [BYTE_W-1:0]    str_q [$];
  int                   items_sent;
  int                   burst_left;
  int                   idle_cycles;
  bit                   hold_req;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  longest_palindromic_substring #(
    .MAX_LEN(DUT_MAX_LEN)
  ) u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_data_byte   (in_data_byte),
    .in_last_byte   (in_last_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_best_start (out_best_start),
    .out_best_length(out_best_length),
    .out_truncated  (out_truncated)
  );

  // Note inputs before checking outputs so one edge is handled in a fixed order.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready)
        sb.note_byte(in_data_byte, in_last_byte);
      if (out_valid && out_ready)
        sb.check_result(out_best_start, out_best_length, out_truncated);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Receiver: steps through four ready patterns in turn; long hold-off on request.
  initial begin
    int cyc;
    out_ready = 1'b0;
    cyc = 0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end else begin
        case ((cyc / 97) % 4)
          0: out_ready <= 1'b1;
          1: out_ready <= 1'($urandom_range(0, 1));
          2: out_ready <= ((cyc % 4) != 3);
          default: out_ready <= ($urandom_range(0, 4) == 0);
        endcase
      end
      cyc++;
    end
  end

  task pace_sender();
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
  endtask

  task send_byte(logic [BYTE_W-1:0] b, logic last);
    @(negedge clk);
    in_valid     <= 1'b1;
    in_data_byte <= b;
    in_last_byte <= last;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  task send_queued();
    for (int k = 0; k < str_q.size(); k++) begin
      pace_sender();
      send_byte(str_q[k], k == str_q.size() - 1);
    end
  endtask

  task send_text(string s);
    str_q.delete();
    for (int k = 0; k < s.len(); k++)
      str_q.push_back(s[k]);
    send_queued();
  endtask

  task drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Fill str_q with one string of the given length and content style.
  task build_string(int len, int kind);
    logic [BYTE_W-1:0] base;
    logic [BYTE_W-1:0] alt;
    int                plen;
    int                pos;
    base = BYTE_W'($urandom_range(0, 255));
    alt  = BYTE_W'($urandom_range(0, 255));
    str_q.delete();
    for (int k = 0; k < len; k++) begin
      case (kind)
        0: str_q.push_back(BYTE_W'($urandom_range(0, 255)));
        1: str_q.push_back(base + BYTE_W'($urandom_range(0, 2)));
        2: str_q.push_back(base + BYTE_W'($urandom_range(0, 3)));
        3: str_q.push_back(base);
        default: str_q.push_back((k % 2 == 0) ? base : alt);
      endcase
    end
    if (kind == 2) begin
      // mirror a random window into a palindrome
      plen = $urandom_range(1, len);
      pos  = $urandom_range(0, len - plen);
      for (int k = 0; k < plen / 2; k++)
        str_q[pos+plen-1-k] = str_q[pos+k];
    end
  endtask

  initial begin
    int strings_done;
    int long_cnt;
    int len;
    sb           = new();
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_data_byte = '0;
    in_last_byte = 1'b0;
    items_sent   = 0;
    burst_left   = 0;
    hold_req     = 1'b0;
    strings_done = 0;
    long_cnt     = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed strings: single bytes at both extremes, ties, even and odd palindromes.
    str_q.delete();
    str_q.push_back(8'h00);
    send_queued();
    str_q.delete();
    str_q.push_back(8'hFF);
    send_queued();
    send_text("ab");
    send_text("aa");
    send_text("aba");
    str_q.delete();
    str_q.push_back(8'hFF);
    str_q.push_back(8'h00);
    str_q.push_back(8'h00);
    str_q.push_back(8'hFF);
    send_queued();
    send_text("abacdc");
    send_text("xyzzy");
    drain_results();

    while (items_sent < ITEM_TARGET) begin
      if (strings_done % 40 == 39) begin
        // long strings: exactly full, one byte over, then random lengths around the limit
        case (long_cnt)
          0: build_string(DUT_MAX_LEN, 3);
          1: build_string(DUT_MAX_LEN + 1, 2);
          default: build_string($urandom_range(DUT_MAX_LEN - 8, DUT_MAX_LEN + 44),
                                $urandom_range(0, 4));
        endcase
        long_cnt++;
      end else begin
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(25, 64) : $urandom_range(1, 24);
        build_string(len, $urandom_range(0, 4));
      end
      send_queued();
      strings_done++;
      if (strings_done == 15)
        hold_req = 1'b1;
      if (strings_done == 60)
        drain_results();
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.fail_count == 0 && sb.pending() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/lps_pkg.sv
rtl/lps_cell.sv
rtl/lps_track.sv
rtl/longest_palindromic_substring.sv
rtl/lps_chk.sv
verif/lps_scoreboard_pkg.sv
verif/tb_longest_palindromic_substring.sv
